### rtl/tmema_pkg.sv
// Shared constants, register codes and divider handshake types for the
// trimmed-mean resistance sensor. No dependencies.
`default_nettype none

package tmema_pkg;

   localparam int CHANNELS_DEF  = 6;
   localparam int BLOCK_LEN_DEF = 20;
   localparam int MAX_CHANNELS  = 6;

   localparam int CHAN_W     = 3;
   localparam int SAMPLE_W   = 16;
   localparam int LEVEL_W    = 32;
   localparam int RES_W      = 32;
   localparam int REG_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int DIVIDEND_W = 48;
   localparam int DIVISOR_W  = 32;
   localparam int QUOT_W     = 32;
   localparam int PROD_W     = 48;

   localparam logic [LEVEL_W-1:0] FULL_Q16 = 32'hFFFF_0000;
   localparam logic [RES_W-1:0]   SAT32    = 32'hFFFF_FFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_GAIN = 3'd6;

   localparam logic [REG_W-1:0] REF_RES_RESET [MAX_CHANNELS] =
      '{16'd5198, 16'd5166, 16'd5300, 16'd5190, 16'd5243, 16'd5060};
   localparam logic [REG_W-1:0] GAIN_RESET = 16'd3277;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

### rtl/tmema_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
// Depends on tmema_pkg for field widths.
`default_nettype none

interface tmema_req_if;
   logic                             valid;
   logic                             ready;
   logic [tmema_pkg::CHAN_W-1:0]     channel;
   logic [tmema_pkg::SAMPLE_W-1:0]   sample;
   modport source (output valid, output channel, output sample, input ready);
   modport sink (input valid, input channel, input sample, output ready);
endinterface

interface tmema_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tmema_pkg::CHAN_W-1:0]   out_channel;
   logic [tmema_pkg::LEVEL_W-1:0]  filtered;
   logic [tmema_pkg::RES_W-1:0]    resistance;
   logic                           saturated;
   modport source (output valid, output out_channel, output filtered, output resistance,
                   output saturated, input ready);
   modport sink (input valid, input out_channel, input filtered, input resistance,
                 input saturated, output ready);
endinterface

interface tmema_csr_if;
   logic                              valid;
   logic                              ready;
   logic [tmema_pkg::CSR_IDX_W-1:0]   index;
   logic [tmema_pkg::REG_W-1:0]       data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/trimmed_mean_ema_resistance_sensor_core.sv
// A sample that does not close its channel's block is taken in the idle state and ready stays high,
// so such samples can follow back to back.
// A sample that closes a block holds ready low while the sequencer steps through trim, mean,
// EMA difference, multiply and add, resistance multiply and check, the divider wait (skipped
// on saturation) and done, where its result beat is loaded; a result still waiting in the output register adds stalls.
// Synchronous reset restores the register defaults and clears all channel statistics and levels.
`default_nettype none

module trimmed_mean_ema_resistance_sensor_core #(
   parameter int CHANNELS  = tmema_pkg::CHANNELS_DEF,
   parameter int BLOCK_LEN = tmema_pkg::BLOCK_LEN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   tmema_req_if.sink    req_chan,
   tmema_rsp_if.source  rsp_chan,
   tmema_csr_if.sink    csr_chan
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = $clog2(BLOCK_LEN + 1);
   localparam int SUM_W = $clog2(BLOCK_LEN * 65535 + 1);
   localparam int SW    = tmema_pkg::SAMPLE_W;
   localparam int LW    = tmema_pkg::LEVEL_W;
   localparam int PW    = tmema_pkg::PROD_W;
   localparam logic [CNT_W-1:0] BLOCK_CNT = CNT_W'(BLOCK_LEN);

   // The trimmed mean is a multiply by a scaled reciprocal of BLOCK_LEN-2, exact for every sum.
   localparam int          RECIP_SH = SUM_W + $clog2(BLOCK_LEN);
   localparam logic [63:0] RECIP    = (64'd1 << RECIP_SH) / 64'(BLOCK_LEN - 2) + 64'd1;
   localparam int          RECIP_W  = $clog2(RECIP + 64'd1);
   localparam int          MP_W     = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

   typedef enum logic [3:0] {
      ST_IDLE, ST_TRIM, ST_MEAN, ST_EMA_DIFF, ST_EMA_MUL, ST_EMA_ADD,
      ST_RES_MUL, ST_RES_CHECK, ST_RES_WAIT, ST_DONE
   } state_type;

   state_type state_ff;

   logic [CNT_W-1:0]            count_ff [CHANNELS];
   logic [SUM_W-1:0]            sum_ff   [CHANNELS];
   logic [SW-1:0]               min_ff   [CHANNELS];
   logic [SW-1:0]               max_ff   [CHANNELS];
   logic [LW-1:0]               level_ff [CHANNELS];
   logic [tmema_pkg::REG_W-1:0] ref_res_ff [CHANNELS];
   logic [tmema_pkg::REG_W-1:0] gain_ff;

   logic [IDX_W-1:0] ch_ff;
   logic [MP_W-1:0]  mean_prod_ff;
   logic [SW-1:0]    mean_ff;
   logic             ge_ff;
   logic [LW-1:0]    diff_ff;
   logic [PW-1:0]    prod_ff;
   logic [LW-1:0]    f_ff;
   logic [PW-1:0]    num_ff;
   logic [LW-1:0]    den_ff;
   logic [tmema_pkg::RES_W-1:0] res_ff;
   logic             sat_ff;

   logic                         rsp_valid_ff;
   logic [tmema_pkg::CHAN_W-1:0] out_chan_ff;
   logic [LW-1:0]                out_filt_ff;
   logic [tmema_pkg::RES_W-1:0]  out_res_ff;
   logic                         out_sat_ff;

   logic [IDX_W-1:0] acc_idx;
   logic             chan_ok;
   logic             accept;
   logic [CNT_W-1:0] cnt_in;
   logic [SUM_W-1:0] sum_in;
   logic [SW-1:0]    min_in;
   logic [SW-1:0]    max_in;
   logic [SUM_W-1:0] trim;
   logic [LW-1:0]    target;
   logic [LW-1:0]    cur_level;
   logic [LW-1:0]    f_in;
   logic             res_sat;
   logic             load_out;

   tmema_pkg::div_req_type div_req;
   tmema_pkg::div_rsp_type div_rsp;

   tmema_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      acc_idx   = req_chan.channel[IDX_W-1:0];
      chan_ok   = req_chan.channel < tmema_pkg::CHAN_W'(CHANNELS);
      accept    = req_chan.valid && req_chan.ready && chan_ok;
      cnt_in    = count_ff[acc_idx] + 1'b1;
      sum_in    = sum_ff[acc_idx] + SUM_W'(req_chan.sample);
      min_in    = (req_chan.sample < min_ff[acc_idx]) ? req_chan.sample : min_ff[acc_idx];
      max_in    = (req_chan.sample > max_ff[acc_idx]) ? req_chan.sample : max_ff[acc_idx];
      trim      = sum_ff[ch_ff] - SUM_W'(min_ff[ch_ff]) - SUM_W'(max_ff[ch_ff]);
      target    = {mean_ff, 16'h0000};
      cur_level = level_ff[ch_ff];
      f_in      = ge_ff ? cur_level + prod_ff[PW-1:16] : cur_level - prod_ff[PW-1:16];
      res_sat   = (den_ff == '0) || (LW'(num_ff[PW-1:LW]) >= den_ff);
      load_out  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

      div_req.start    = (state_ff == ST_RES_CHECK) && !res_sat;
      div_req.dividend = num_ff;
      div_req.divisor  = den_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= tmema_pkg::GAIN_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            count_ff[i]   <= '0;
            sum_ff[i]     <= '0;
            min_ff[i]     <= '1;
            max_ff[i]     <= '0;
            level_ff[i]   <= '0;
            ref_res_ff[i] <= tmema_pkg::REF_RES_RESET[i];
         end
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            if (csr_chan.index == tmema_pkg::CSR_SMOOTHING_GAIN) begin
               gain_ff <= csr_chan.data;
            end else if (csr_chan.index < tmema_pkg::CSR_IDX_W'(CHANNELS)) begin
               ref_res_ff[csr_chan.index[IDX_W-1:0]] <= csr_chan.data;
            end
         end

         if (rsp_valid_ff && rsp_chan.ready && !load_out) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  count_ff[acc_idx] <= cnt_in;
                  sum_ff[acc_idx]   <= sum_in;
                  min_ff[acc_idx]   <= min_in;
                  max_ff[acc_idx]   <= max_in;
                  ch_ff             <= acc_idx;
                  if (cnt_in == BLOCK_CNT) begin
                     state_ff <= ST_TRIM;
                  end
               end
            end
            ST_TRIM: begin
               mean_prod_ff    <= MP_W'(trim) * MP_W'(RECIP_K);
               count_ff[ch_ff] <= '0;
               sum_ff[ch_ff]   <= '0;
               min_ff[ch_ff]   <= '1;
               max_ff[ch_ff]   <= '0;
               state_ff        <= ST_MEAN;
            end
            ST_MEAN: begin
               mean_ff  <= SW'(mean_prod_ff >> RECIP_SH);
               state_ff <= ST_EMA_DIFF;
            end
            ST_EMA_DIFF: begin
               ge_ff    <= target >= cur_level;
               diff_ff  <= (target >= cur_level) ? target - cur_level : cur_level - target;
               state_ff <= ST_EMA_MUL;
            end
            ST_EMA_MUL: begin
               prod_ff  <= PW'(diff_ff) * PW'(gain_ff);
               state_ff <= ST_EMA_ADD;
            end
            ST_EMA_ADD: begin
               level_ff[ch_ff] <= f_in;
               f_ff            <= f_in;
               state_ff        <= ST_RES_MUL;
            end
            ST_RES_MUL: begin
               num_ff   <= PW'(ref_res_ff[ch_ff]) * PW'(f_ff);
               den_ff   <= tmema_pkg::FULL_Q16 - f_ff;
               state_ff <= ST_RES_CHECK;
            end
            ST_RES_CHECK: begin
               sat_ff <= res_sat;
               if (res_sat) begin
                  res_ff   <= tmema_pkg::SAT32;
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_RES_WAIT;
               end
            end
            ST_RES_WAIT: begin
               if (div_rsp.done) begin
                  res_ff   <= div_rsp.quotient;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (load_out) begin
                  rsp_valid_ff <= 1'b1;
                  out_chan_ff  <= tmema_pkg::CHAN_W'(ch_ff);
                  out_filt_ff  <= f_ff;
                  out_res_ff   <= res_ff;
                  out_sat_ff   <= sat_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_channel = out_chan_ff;
   assign rsp_chan.filtered    = out_filt_ff;
   assign rsp_chan.resistance  = out_res_ff;
   assign rsp_chan.saturated   = out_sat_ff;

   a_div_done_state : assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_RES_WAIT))
      else $error("Divider finished outside a wait state.");

   a_sat_value : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_sat_ff |-> out_res_ff == tmema_pkg::SAT32)
      else $error("Saturated beat without a saturated resistance.");

   a_full_scale_sat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (out_filt_ff == tmema_pkg::FULL_Q16) |-> out_sat_ff)
      else $error("Full-scale level did not raise saturation.");

   a_load_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("Result beat raised outside the done state.");

endmodule

`default_nettype wire

### rtl/tmema_div.sv
// Shared restoring divider, one quotient bit per cycle, 32 steps.
// Depends on tmema_pkg. The upper dividend bits must be below the divisor.
`default_nettype none

module tmema_div (
   input  logic                   clock,
   input  logic                   reset,
   input  tmema_pkg::div_req_type div_req,
   output tmema_pkg::div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(tmema_pkg::QUOT_W);
   localparam int HI_W  = tmema_pkg::DIVIDEND_W - tmema_pkg::QUOT_W;

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic [tmema_pkg::DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [tmema_pkg::QUOT_W-1:0]      low_ff, low_in;
   logic [tmema_pkg::DIVISOR_W-1:0]   divisor_ff, divisor_in;
   logic [tmema_pkg::DIVISOR_W:0]     trial;
   logic                              fits;

   always_comb begin
      trial      = {rem_ff, low_ff[tmema_pkg::QUOT_W-1]};
      fits       = trial >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      low_in     = low_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_W'(tmema_pkg::QUOT_W - 1);
         rem_in     = tmema_pkg::DIVISOR_W'(div_req.dividend[tmema_pkg::DIVIDEND_W-1 -: HI_W]);
         low_in     = div_req.dividend[tmema_pkg::QUOT_W-1:0];
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? tmema_pkg::DIVISOR_W'(trial - {1'b0, divisor_ff})
                       : tmema_pkg::DIVISOR_W'(trial);
         low_in = {low_ff[tmema_pkg::QUOT_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = low_ff;

   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("Divider started while busy.");

   a_start_range : assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (tmema_pkg::DIVISOR_W'(div_req.dividend[tmema_pkg::DIVIDEND_W-1 -: HI_W])
                         < div_req.divisor))
      else $error("Divider started with a quotient that does not fit.");

   a_done_after_busy : assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> $past(busy_ff) && !busy_ff)
      else $error("Divider done without a finished run.");

endmodule

`default_nettype wire
